// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/olv_pkg.sv -----
package olv_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 5;
  localparam int COUNT_W  = 6;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_DELETE = 2'd3;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_DELETED   = 3'd5;
  localparam logic [2:0] ST_ELEMENT   = 3'd6;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [VAL_W-1:0] item_value;
  } request_t;

  typedef struct packed {
    logic [2:0]              status;
    logic signed [VAL_W-1:0] element;
    logic [POS_W-1:0]        position;
    logic [COUNT_W-1:0]      entry_count;
    logic                    last;
  } result_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE,
    CELL_CLOSE
  } cell_mode_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_mode_t       mode;
    idx_t             sel;
    logic [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

// ----- hdl/olv_cell.sv -----
module olv_cell (
  input  logic                     clk,
  input  olv_pkg::idx_t            idx,
  input  olv_pkg::cell_cmd_t       cmd,
  input  logic [olv_pkg::VAL_W-1:0] nxt,
  output logic [olv_pkg::VAL_W-1:0] value
);
  import olv_pkg::*;

  // rotate: every cell takes its upper neighbor, the top cell wraps to the head
  // close: cells at or above the removed entry take their upper neighbor
  always_ff @(posedge clk) begin
    case (cmd.mode)
      CELL_INSERT: begin
        if (idx == cmd.sel) value <= cmd.value;
      end
      CELL_ROTATE: value <= nxt;
      CELL_CLOSE: begin
        if (idx >= cmd.sel) value <= nxt;
      end
      default: value <= value;
    endcase
  end

endmodule

// ----- hdl/ordered_value_list_top.sv -----
// Insert, and any request on an empty list: result in the cycle after acceptance;
// busy stays low, so a new request can be taken every cycle.
// Search, read-out, delete: the cell chain makes one full rotation through all
// CAPACITY cells; results come out during it (read-out) or right after, and a delete
// that finds its value adds a CLOSE state. busy is high for the whole request.
// Synchronous reset empties the list; cell contents are not cleared.
module ordered_value_list_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  olv_pkg::request_t request,
  output logic              busy,
  output logic              result_valid,
  output olv_pkg::result_t  result
);
  import olv_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    CLOSE
  } state_t;

  state_t           state;
  logic [1:0]       op;
  logic [VAL_W-1:0] value;
  cnt_t             fill;
  idx_t             k;
  logic             hit;
  idx_t             pos;

  logic [VAL_W-1:0] cells [CAPACITY];
  cell_cmd_t        cmd;

  logic             in_range;
  logic             match_now;
  logic             hit_next;
  idx_t             pos_next;
  logic             accept;
  logic             quick;

  assign busy     = (state != IDLE);
  assign accept   = start && (state == IDLE);
  assign in_range = (CNT_W'(k) < fill);
  assign match_now = (state == SCAN) && in_range && !hit && (cells[0] == value);
  assign hit_next = hit || match_now;
  assign pos_next = match_now ? k : pos;
  assign quick    = accept && (request.opcode == OP_INSERT || fill == '0);

  always_comb begin
    cmd.mode  = CELL_HOLD;
    cmd.sel   = fill[IDX_W-1:0];
    cmd.value = request.item_value;
    case (state)
      IDLE: begin
        if (accept && request.opcode == OP_INSERT && fill != CNT_W'(CAPACITY))
          cmd.mode = CELL_INSERT;
      end
      SCAN:  cmd.mode = CELL_ROTATE;
      CLOSE: begin
        cmd.mode = CELL_CLOSE;
        cmd.sel  = pos;
      end
      default: cmd.mode = CELL_HOLD;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    olv_cell u_cell (
      .clk   (clk),
      .idx   (IDX_W'(i)),
      .cmd   (cmd),
      .nxt   (cells[(i + 1) % CAPACITY]),
      .value (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      fill         <= '0;
      k            <= '0;
      hit          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (accept) begin
            op     <= request.opcode;
            value  <= request.item_value;
            k      <= '0;
            hit    <= 1'b0;
            pos    <= '0;
            result.element     <= request.item_value;
            result.position    <= '0;
            result.entry_count <= COUNT_W'(fill);
            result.last        <= 1'b1;
            if (request.opcode == OP_INSERT) begin
              result_valid <= 1'b1;
              if (fill == CNT_W'(CAPACITY)) begin
                result.status <= ST_FULL;
              end else begin
                result.status      <= ST_INSERTED;
                result.position    <= POS_W'(fill);
                result.entry_count <= COUNT_W'(fill + 1'b1);
                fill               <= fill + 1'b1;
              end
            end else if (fill == '0) begin
              result_valid  <= 1'b1;
              result.status <= ST_EMPTY;
              if (request.opcode == OP_READ) result.element <= '0;
            end else begin
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          k   <= k + 1'b1;
          hit <= hit_next;
          pos <= pos_next;
          if (op == OP_READ && in_range) begin
            result_valid       <= 1'b1;
            result.status      <= ST_ELEMENT;
            result.element     <= cells[0];
            result.position    <= POS_W'(k);
            result.entry_count <= COUNT_W'(fill);
            result.last        <= (CNT_W'(k) + 1'b1 == fill);
          end
          if (k == IDX_W'(CAPACITY - 1)) begin
            state <= IDLE;
            if (op != OP_READ) begin
              result.element     <= value;
              result.entry_count <= COUNT_W'(fill);
              result.last        <= 1'b1;
              if (!hit_next) begin
                result_valid    <= 1'b1;
                result.status   <= ST_NOT_FOUND;
                result.position <= '0;
              end else if (op == OP_SEARCH) begin
                result_valid    <= 1'b1;
                result.status   <= ST_FOUND;
                result.position <= POS_W'(pos_next);
              end else begin
                state <= CLOSE;
              end
            end
          end
        end
        CLOSE: begin
          state              <= IDLE;
          fill               <= fill - 1'b1;
          result_valid       <= 1'b1;
          result.status      <= ST_DELETED;
          result.element     <= value;
          result.position    <= POS_W'(pos);
          result.entry_count <= COUNT_W'(fill - 1'b1);
          result.last        <= 1'b1;
        end
        default: state <= IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_reset_idle, rst |=> !busy && !result_valid, "not idle after reset")
  `ASSERT_CLK(a_fill_bound, fill <= CNT_W'(CAPACITY), "fill count above capacity")
  `ASSERT_CLK(a_quick_result, quick |=> result_valid && result.last, "no quick result")
  `ASSERT_CLK(a_close_entry, state == CLOSE |-> $past(state) == SCAN && hit, "close, no match")
  `ASSERT_CLK(a_delete_count, result_valid && result.status == ST_DELETED |-> fill + 1'b1 == $past(fill), "delete did not shrink the list")

endmodule
